// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Each macro expects a signal named clk, and ASSERT_CLK also one named rst, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is active.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dbtr_pkg.sv =====
// Package for the double-buffered tile reorder block: widths, register indexes, types.
// No dependencies; every other file of the block refers to it by scoped names.
package dbtr_pkg;

  localparam int TILE_ROWS   = 8;
  localparam int DEF_MAX_DIM = 1024;

  localparam int LANE_W  = 64;
  localparam int LANES   = 4;
  localparam int WORD_W  = LANE_W * LANES;

  localparam int TILE_W  = 18;

  localparam int BPR_W   = 11;
  localparam int ROWS_W  = 11;
  localparam int BATCH_W = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE        = 3'd4;

  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;

  typedef struct packed {
    logic emit;
    logic last;
  } ctl_t;

endpackage

// ===== sv/dbtr_ifs.sv =====
// Valid/ready channel interfaces for the input and result beats of the reorder block.
// Depends on dbtr_pkg for the lane width.
interface dbtr_in_if;
  logic                      valid;
  logic                      ready;
  logic [dbtr_pkg::LANE_W-1:0] lane_0;
  logic [dbtr_pkg::LANE_W-1:0] lane_1;
  logic [dbtr_pkg::LANE_W-1:0] lane_2;
  logic [dbtr_pkg::LANE_W-1:0] lane_3;

  modport source (output valid, lane_0, lane_1, lane_2, lane_3, input ready);
  modport sink (input valid, lane_0, lane_1, lane_2, lane_3, output ready);
endinterface

interface dbtr_out_if;
  logic                      valid;
  logic                      ready;
  logic [dbtr_pkg::LANE_W-1:0] out_lane_0;
  logic [dbtr_pkg::LANE_W-1:0] out_lane_1;
  logic [dbtr_pkg::LANE_W-1:0] out_lane_2;
  logic [dbtr_pkg::LANE_W-1:0] out_lane_3;
  logic                      last;

  modport source (output valid, out_lane_0, out_lane_1, out_lane_2, out_lane_3, last,
                  input ready);
  modport sink (input valid, out_lane_0, out_lane_1, out_lane_2, out_lane_3, last,
                output ready);
endinterface

// ===== sv/dbtr_ram.sv =====
// Ping-pong word memory: one write port and one read port, registered read data.
// Depends on dbtr_pkg for the word width.
module dbtr_ram #(
  parameter int ADDR_W = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [dbtr_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [dbtr_pkg::WORD_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [dbtr_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dbtr_seq.sv =====
// Configuration registers, tile counters and address generation for the reorder block.
// Depends on dbtr_pkg and the dbtr_in_if interface.
module dbtr_seq #(
  parameter int MAX_DIM = dbtr_pkg::DEF_MAX_DIM,
  parameter int HALF_W  = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dbtr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dbtr_pkg::CFG_DATA_W-1:0] cfg_data,
  dbtr_in_if.sink                        din,
  input  logic                           space,
  output logic                           ram_we,
  output logic [HALF_W:0]                ram_waddr,
  output logic [dbtr_pkg::WORD_W-1:0]    ram_wdata,
  output logic                           ram_re,
  output logic [HALF_W:0]                ram_raddr,
  output dbtr_pkg::ctl_t                 push
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int PROD_W = dbtr_pkg::BATCH_W + DIM_W;
  localparam int TW     = dbtr_pkg::TILE_W;
  localparam int CMP_W  = (TW + 3 > PROD_W) ? TW + 3 : PROD_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v);
    if (v == 11'd0) begin
      return DIM_W'(1);
    end
    if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  logic [dbtr_pkg::BPR_W-1:0]   bpr;
  logic [dbtr_pkg::ROWS_W-1:0]  rows;
  logic [dbtr_pkg::BATCH_W-1:0] batch;
  logic                         direction;
  logic                         inverse;
  logic                         cfg_hit;
  logic [1:0]                   settle;

  logic [DIM_W-1:0]             tx;
  logic [DIM_W-1:0]             ty;
  logic [PROD_W-1:0]            prod_rows;
  logic [PROD_W-1:0]            prod_cols;
  logic [PROD_W-1:0]            pad_limit;
  logic [TW-1:0]                last_tile;

  logic [DIM_W-1:0]             bpr_c;
  logic [DIM_W-1:0]             rows_c;
  logic [dbtr_pkg::BATCH_W-1:0] batch_c;
  logic [PROD_W:0]              tiles_sum;

  logic [TW-1:0]                tile_index;
  logic [CNT_W-1:0]             row_in_tile;
  logic [CNT_W-1:0]             col_in_tile;
  logic [HALF_W-1:0]            raddr_rm;
  logic [HALF_W-1:0]            raddr_cm;
  logic [TW-1:0]                tile_index_next;
  logic [CNT_W-1:0]             row_in_tile_next;
  logic [CNT_W-1:0]             col_in_tile_next;
  logic [HALF_W-1:0]            raddr_rm_next;
  logic [HALF_W-1:0]            raddr_cm_next;

  logic                         accept;
  logic                         row_end;
  logic                         tile_end;
  logic                         is_last;
  logic                         pad;
  logic [dbtr_pkg::WORD_W-1:0]  in_word;

  assign cfg_hit = cfg_we && (cfg_idx <= dbtr_pkg::REG_INVERSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bpr       <= dbtr_pkg::BPR_W'(1);
      rows      <= dbtr_pkg::ROWS_W'(1);
      batch     <= dbtr_pkg::BATCH_W'(1);
      direction <= 1'b0;
      inverse   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        dbtr_pkg::REG_BLOCKS_PER_ROW: bpr <= cfg_data[dbtr_pkg::BPR_W-1:0];
        dbtr_pkg::REG_ROWS:           rows <= cfg_data[dbtr_pkg::ROWS_W-1:0];
        dbtr_pkg::REG_BATCH:          batch <= cfg_data[dbtr_pkg::BATCH_W-1:0];
        dbtr_pkg::REG_DIRECTION:      direction <= cfg_data[0];
        dbtr_pkg::REG_INVERSE:        inverse <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Tile geometry and pass limits are derived over two register stages.
  assign bpr_c   = clamp_dim(bpr);
  assign rows_c  = clamp_dim(rows);
  assign batch_c = (batch == '0) ? dbtr_pkg::BATCH_W'(1) : batch;
  assign tiles_sum = (direction ? {1'b0, prod_cols} : {1'b0, prod_rows}) + (PROD_W + 1)'(7);

  always_ff @(posedge clk) begin
    tx        <= direction ? DIM_W'(dbtr_pkg::TILE_ROWS) : bpr_c;
    ty        <= direction ? rows_c : DIM_W'(dbtr_pkg::TILE_ROWS);
    prod_rows <= PROD_W'(batch_c) * PROD_W'(rows_c);
    prod_cols <= PROD_W'(batch_c) * PROD_W'(bpr_c);
    pad_limit <= prod_rows;
    last_tile <= TW'(tiles_sum >> 3);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign din.ready = (settle == 2'd0) && space;
  assign accept    = din.valid && din.ready;
  assign in_word   = {din.lane_3, din.lane_2, din.lane_1, din.lane_0};

  assign row_end  = (DIM_W'(col_in_tile) == tx - DIM_W'(1));
  assign tile_end = row_end && (DIM_W'(row_in_tile) == ty - DIM_W'(1));
  assign is_last  = tile_end && (tile_index == last_tile);
  assign pad      = !direction &&
                    (CMP_W'({tile_index, row_in_tile[2:0]}) >= CMP_W'(pad_limit));

  assign ram_we    = accept;
  assign ram_waddr = {tile_index[0], inverse ? raddr_rm : raddr_cm};
  assign ram_wdata = pad ? '0 : in_word;
  assign ram_re    = accept && (tile_index != '0);
  assign ram_raddr = {~tile_index[0], inverse ? raddr_cm : raddr_rm};

  assign push.emit = accept && (tile_index != '0);
  assign push.last = is_last;

  always_comb begin
    tile_index_next  = tile_index;
    row_in_tile_next = row_in_tile;
    col_in_tile_next = col_in_tile;
    raddr_rm_next    = raddr_rm;
    raddr_cm_next    = raddr_cm;
    if (is_last) begin
      tile_index_next  = '0;
      row_in_tile_next = '0;
      col_in_tile_next = '0;
      raddr_rm_next    = '0;
      raddr_cm_next    = '0;
    end else if (tile_end) begin
      tile_index_next  = tile_index + TW'(1);
      row_in_tile_next = '0;
      col_in_tile_next = '0;
      raddr_rm_next    = '0;
      raddr_cm_next    = '0;
    end else if (row_end) begin
      row_in_tile_next = row_in_tile + CNT_W'(1);
      col_in_tile_next = '0;
      raddr_rm_next    = raddr_rm + HALF_W'(1);
      raddr_cm_next    = HALF_W'(row_in_tile) + HALF_W'(1);
    end else begin
      col_in_tile_next = col_in_tile + CNT_W'(1);
      raddr_rm_next    = raddr_rm + HALF_W'(1);
      raddr_cm_next    = raddr_cm + HALF_W'(ty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      tile_index  <= '0;
      row_in_tile <= '0;
      col_in_tile <= '0;
      raddr_rm    <= '0;
      raddr_cm    <= '0;
    end else if (accept) begin
      tile_index  <= tile_index_next;
      row_in_tile <= row_in_tile_next;
      col_in_tile <= col_in_tile_next;
      raddr_rm    <= raddr_rm_next;
      raddr_cm    <= raddr_cm_next;
    end
  end

endmodule

// ===== sv/dbtr_outq.sv =====
// Read-return stage and three-entry result queue that drives the output channel.
// Depends on dbtr_pkg and the dbtr_out_if interface.
module dbtr_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  dbtr_pkg::ctl_t              push,
  input  logic [dbtr_pkg::WORD_W-1:0] rdata,
  output logic                        space,
  dbtr_out_if.source                  dout
);

  localparam int PW = dbtr_pkg::OQ_PTR_W;

  logic [dbtr_pkg::WORD_W-1:0] q_word [dbtr_pkg::OQ_DEPTH];
  logic                        q_last [dbtr_pkg::OQ_DEPTH];
  logic [PW-1:0]               wr_ptr;
  logic [PW-1:0]               rd_ptr;
  logic [PW-1:0]               cnt;
  logic                        s1_valid;
  logic                        s1_last;
  logic                        pop;

  assign pop   = dout.valid && dout.ready;
  assign space = ({1'b0, cnt} + {{PW{1'b0}}, s1_valid}) < (PW + 1)'(dbtr_pkg::OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      cnt      <= '0;
    end else begin
      s1_valid <= push.emit;
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == PW'(dbtr_pkg::OQ_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(dbtr_pkg::OQ_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      cnt <= cnt + PW'(s1_valid) - PW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= push.last;
    if (s1_valid) begin
      q_word[wr_ptr] <= rdata;
      q_last[wr_ptr] <= s1_last;
    end
  end

  assign dout.valid      = (cnt != '0);
  assign dout.out_lane_0 = q_word[rd_ptr][63:0];
  assign dout.out_lane_1 = q_word[rd_ptr][127:64];
  assign dout.out_lane_2 = q_word[rd_ptr][191:128];
  assign dout.out_lane_3 = q_word[rd_ptr][255:192];
  assign dout.last       = q_last[rd_ptr];

endmodule

// ===== sv/double_buffered_tile_reorder.sv =====
// Top level of the double-buffered tile reorder block.
// Depends on dbtr_pkg, dbtr_ifs, dbtr_seq, dbtr_ram and dbtr_outq.
//
//   channel | direction | payload                                    | beat when
//   din     | in        | lane_0..lane_3 (4 x 64 bits)               | valid & ready
//   dout    | out       | out_lane_0..out_lane_3 (4 x 64 bits), last | valid & ready
//   cfg     | in        | cfg_idx (3 bits), cfg_data (14 bits)       | cfg_we
//
// One input beat per cycle unless din is held off; every beat writes one memory
// word and, from the second tile of a pass on, reads one, so the single read/write
// port pair sets the rate. A result reaches dout through the read register and the
// result queue. The queue holds three results, so din keeps flowing while dout
// stalls until it fills. After reset and after each write to one of the five
// registers, din is held off while the tile geometry settles.
module double_buffered_tile_reorder #(
  parameter int MAX_DIM = dbtr_pkg::DEF_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  dbtr_in_if.sink                         din,
  dbtr_out_if.source                      dout,
  input  logic                            cfg_we,
  input  logic [dbtr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dbtr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF_W = $clog2(MAX_DIM * dbtr_pkg::TILE_ROWS);
  localparam int ADDR_W = HALF_W + 1;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [dbtr_pkg::WORD_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [dbtr_pkg::WORD_W-1:0] ram_rdata;
  logic                        space;
  dbtr_pkg::ctl_t              push;

  dbtr_seq #(
    .MAX_DIM (MAX_DIM),
    .HALF_W  (HALF_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .din       (din),
    .space     (space),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .push      (push)
  );

  dbtr_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dbtr_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .rdata (ram_rdata),
    .space (space),
    .dout  (dout)
  );

endmodule

// ===== sv/dbtr_chk.sv =====
// Port-level checker for the double-buffered tile reorder block, bound to the top level.
// Depends on dbtr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbtr_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_last,
  input logic                           cfg_we,
  input logic [dbtr_pkg::CFG_IDX_W-1:0] cfg_idx
);

  `ASSERT_ALWAYS(a_reset_holds_input, rst |=> !in_ready, "input taken right after reset")

  `ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "result pending after reset")

  `ASSERT_CLK(a_cfg_holds_input, cfg_we && (cfg_idx <= dbtr_pkg::REG_INVERSE) |=> !in_ready ##1 !in_ready, "input taken while geometry settles")

  `ASSERT_CLK(a_out_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_last), "stalled result beat changed")

endmodule

bind double_buffered_tile_reorder dbtr_chk u_dbtr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_last  (dout.last),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx)
);

// ===== sim/double_buffered_tile_reorder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_buffered_tile_reorder: beats go in through din,
// results are checked against an in-bench ping-pong tile reorder predictor.
// Depends on dbtr_pkg, dbtr_ifs and the block's RTL.
module double_buffered_tile_reorder_tb;

  localparam int          HALF_WORDS    = dbtr_pkg::DEF_MAX_DIM * dbtr_pkg::TILE_ROWS;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          DRAIN_CYCLES  = 10;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          RANDOM_BEATS  = 1200;

  typedef logic [dbtr_pkg::LANES-1:0][dbtr_pkg::LANE_W-1:0] word_t;

  typedef struct {
    word_t word;
    logic  last;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [dbtr_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [dbtr_pkg::CFG_DATA_W-1:0] reg_val;
    word_t                           word;
    logic                            pinned;
    word_t                           want_word;
    logic                            want_last;
  } dir_row_t;

  localparam word_t W_ZERO = '0;
  localparam word_t W_ONES = '1;
  localparam word_t W_A    = {4{64'hAAAA_AAAA_AAAA_AAAA}};
  localparam word_t W_5    = {4{64'h5555_5555_5555_5555}};
  localparam word_t W_MIX  = {64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
                              64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [dbtr_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [dbtr_pkg::CFG_DATA_W-1:0] cfg_data;

  dbtr_in_if  din_ch ();
  dbtr_out_if dout_ch ();

  double_buffered_tile_reorder DUT (
    .clk      (clk),
    .rst      (rst),
    .din      (din_ch),
    .dout     (dout_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predictor copy of the registers, counters and both halves of the memory.
  logic [dbtr_pkg::BPR_W-1:0]   set_bpr;
  logic [dbtr_pkg::ROWS_W-1:0]  set_rows;
  logic [dbtr_pkg::BATCH_W-1:0] set_batch;
  logic                         set_dir;
  logic                         set_inv;
  logic [dbtr_pkg::TILE_W-1:0]  tile_idx;
  logic [11:0]                  row_idx;
  logic [11:0]                  col_idx;
  word_t                        word_store [0:2*HALF_WORDS-1];

  result_t  pending_results [$];
  dir_row_t directed_rows [0:20];

  bit send_idle;
  bit recv_idle;
  int errors;
  int beats_sent;
  int results_checked;
  int pass_ends;
  int phases_run;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned clamp_extent(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > dbtr_pkg::DEF_MAX_DIM) return dbtr_pkg::DEF_MAX_DIM;
    return v;
  endfunction

  function automatic void tile_geometry(output longint unsigned tx, output longint unsigned ty,
                                        output longint unsigned last_t,
                                        output longint unsigned data_rows);
    longint unsigned bpr;
    longint unsigned nr;
    longint unsigned nb;
    longint unsigned ntiles;
    bpr = clamp_extent(set_bpr);
    nr = clamp_extent(set_rows);
    nb = (set_batch == 0) ? 1 : set_batch;
    data_rows = nb * nr;
    if (!set_dir) begin
      tx = bpr;
      ty = dbtr_pkg::TILE_ROWS;
      ntiles = (data_rows + dbtr_pkg::TILE_ROWS - 1) / dbtr_pkg::TILE_ROWS;
    end else begin
      tx = dbtr_pkg::TILE_ROWS;
      ty = nr;
      ntiles = (bpr * nb + dbtr_pkg::TILE_ROWS - 1) / dbtr_pkg::TILE_ROWS;
    end
    last_t = ntiles % (64'd1 << dbtr_pkg::TILE_W);
  endfunction

  // Writes one slot into the current half, reads the other half in the opposite order.
  function automatic bit reorder_step(input word_t w, output word_t rd, output logic at_end);
    longint unsigned tx;
    longint unsigned ty;
    longint unsigned last_t;
    longint unsigned data_rows;
    longint unsigned widx;
    longint unsigned ridx;
    bit              row_end;
    bit              tile_end;
    bit              emit;
    tile_geometry(tx, ty, last_t, data_rows);
    if (set_inv) begin
      widx = row_idx * tx + col_idx;
      ridx = col_idx * ty + row_idx;
    end else begin
      widx = col_idx * ty + row_idx;
      ridx = row_idx * tx + col_idx;
    end
    widx = (widx % HALF_WORDS) + (tile_idx[0] ? HALF_WORDS : 0);
    ridx = (ridx % HALF_WORDS) + (tile_idx[0] ? 0 : HALF_WORDS);
    if (set_dir || (tile_idx * ty + row_idx < data_rows)) begin
      word_store[widx] = w;
    end else begin
      word_store[widx] = '0;
    end
    row_end = (col_idx == tx - 1);
    tile_end = row_end && (row_idx == ty - 1);
    at_end = tile_end && (tile_idx == last_t);
    emit = (tile_idx != 0);
    rd = word_store[ridx];
    if (at_end) begin
      tile_idx = '0;
      row_idx = '0;
      col_idx = '0;
    end else if (tile_end) begin
      tile_idx = tile_idx + 1'b1;
      row_idx = '0;
      col_idx = '0;
    end else if (row_end) begin
      row_idx = row_idx + 1'b1;
      col_idx = '0;
    end else begin
      col_idx = col_idx + 1'b1;
    end
    return emit;
  endfunction

  // Waits for the block to go quiet, then writes the selected registers back to back.
  task automatic program_regs(input logic [4:0] sel,
                              input logic [4:0][dbtr_pkg::CFG_DATA_W-1:0] vals);
    logic [dbtr_pkg::CFG_IDX_W-1:0] idx;
    din_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = dbtr_pkg::REG_BLOCKS_PER_ROW; r <= dbtr_pkg::REG_INVERSE; r++) begin
      idx = r[dbtr_pkg::CFG_IDX_W-1:0];
      if (sel[idx]) begin
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= vals[idx];
        case (idx)
          dbtr_pkg::REG_BLOCKS_PER_ROW: set_bpr = vals[idx][dbtr_pkg::BPR_W-1:0];
          dbtr_pkg::REG_ROWS:           set_rows = vals[idx][dbtr_pkg::ROWS_W-1:0];
          dbtr_pkg::REG_BATCH:          set_batch = vals[idx][dbtr_pkg::BATCH_W-1:0];
          dbtr_pkg::REG_DIRECTION:      set_dir = vals[idx][0];
          dbtr_pkg::REG_INVERSE:        set_inv = vals[idx][0];
          default: ;
        endcase
        tile_idx = '0;
        row_idx = '0;
        col_idx = '0;
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input word_t w, input logic pinned, input word_t want,
                           input logic want_last);
    int      gap;
    word_t   rd;
    logic    at_end;
    result_t res;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid <= 1'b1;
    din_ch.lane_0 <= w[0];
    din_ch.lane_1 <= w[1];
    din_ch.lane_2 <= w[2];
    din_ch.lane_3 <= w[3];
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    beats_sent++;
    if (reorder_step(w, rd, at_end)) begin
      res.word = pinned ? want : rd;
      res.last = pinned ? want_last : at_end;
      pending_results.push_back(res);
    end
  endtask

  function automatic logic [10:0] pick_extent(input bit narrow);
    if (narrow) return ($urandom_range(0, 5) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
    case ($urandom_range(0, 5))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'd2047;
      2: return 11'd1024;
      default: return 11'($urandom_range(1, 24));
    endcase
  endfunction

  // One register setting followed by random beats; a beat count of zero picks a length
  // of one to three passes and at times part of one more for short passes, or a few tiles.
  task automatic run_phase(input logic [10:0] bpr, input logic [10:0] nrows,
                           input logic [13:0] nbatch, input logic dir, input logic inv,
                           input int nbeats);
    logic [4:0][dbtr_pkg::CFG_DATA_W-1:0] vals;
    longint unsigned                      tx;
    longint unsigned                      ty;
    longint unsigned                      last_t;
    longint unsigned                      data_rows;
    int                                   tile;
    int                                   pass_len;
    int                                   n;
    word_t                                w;
    vals = '0;
    vals[dbtr_pkg::REG_BLOCKS_PER_ROW] = {3'($urandom_range(0, 7)), bpr};
    vals[dbtr_pkg::REG_ROWS] = {3'($urandom_range(0, 7)), nrows};
    vals[dbtr_pkg::REG_BATCH] = nbatch;
    vals[dbtr_pkg::REG_DIRECTION] = {13'($urandom), dir};
    vals[dbtr_pkg::REG_INVERSE] = {13'($urandom), inv};
    program_regs(5'b11111, vals);
    phases_run++;
    send_idle = ($urandom_range(0, 2) != 0);
    recv_idle = ($urandom_range(0, 2) != 0);
    n = nbeats;
    if (n == 0) begin
      tile_geometry(tx, ty, last_t, data_rows);
      tile = int'(tx * ty);
      pass_len = int'((last_t + 1) * tx * ty);
      if ((last_t + 1) * tx * ty <= 160) begin
        n = pass_len * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, pass_len - 1);
      end else begin
        n = tile * $urandom_range(2, 5) + $urandom_range(0, tile - 1);
      end
    end
    for (int b = 0; b < n; b++) begin
      for (int l = 0; l < dbtr_pkg::LANES; l++) begin
        case ($urandom_range(0, 7))
          0: w[l] = '0;
          1: w[l] = '1;
          default: w[l] = {$urandom, $urandom};
        endcase
      end
      send_beat(w, 1'b0, W_ZERO, 1'b0);
    end
  endtask

  initial begin
    int                                   rstart;
    logic [4:0][dbtr_pkg::CFG_DATA_W-1:0] vals;
    logic                                 dir;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = dbtr_pkg::REG_BLOCKS_PER_ROW;
    cfg_data = '0;
    din_ch.valid = 1'b0;
    din_ch.lane_0 = '0;
    din_ch.lane_1 = '0;
    din_ch.lane_2 = '0;
    din_ch.lane_3 = '0;
    set_bpr = dbtr_pkg::BPR_W'(1);
    set_rows = dbtr_pkg::ROWS_W'(1);
    set_batch = dbtr_pkg::BATCH_W'(1);
    set_dir = 1'b0;
    set_inv = 1'b0;
    tile_idx = '0;
    row_idx = '0;
    col_idx = '0;
    errors = 0;
    beats_sent = 0;
    results_checked = 0;
    pass_ends = 0;
    phases_run = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;

    // Reset setting: 1x8 tiles, one grid row, so rows 1..7 of the first tile are padding
    // and the drain tile returns the first word followed by zeros.
    directed_rows = '{
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_ONES, 1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_A,    1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_5,    1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_MIX,  1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_A,    1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_5,    1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_MIX,  1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_ZERO, 1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_A,    1'b1, W_ONES, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_5,    1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_MIX,  1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_ONES, 1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_A,    1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_5,    1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_MIX,  1'b1, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_ONES, 1'b1, W_ZERO, 1'b1},
      '{ROW_WRITE, dbtr_pkg::REG_DIRECTION,     14'd1, W_ZERO, 1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_MIX,  1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_A,    1'b0, W_ZERO, 1'b0},
      '{ROW_BEAT, dbtr_pkg::REG_BLOCKS_PER_ROW, 14'd0, W_5,    1'b0, W_ZERO, 1'b0},
      '{ROW_WRITE, dbtr_pkg::REG_INVERSE,       14'd1, W_ZERO, 1'b0, W_ZERO, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        vals = '0;
        vals[directed_rows[r].reg_idx] = directed_rows[r].reg_val;
        program_regs(5'b00001 << directed_rows[r].reg_idx, vals);
      end else begin
        send_beat(directed_rows[r].word, directed_rows[r].pinned, directed_rows[r].want_word,
                  directed_rows[r].want_last);
      end
    end

    // Padding, clamping, batch of zero, tile count wrap and the start of the widest tile.
    run_phase(11'd1, 11'd3, 14'd1, 1'b0, 1'b0, 32);
    run_phase(11'd2, 11'd5, 14'd3, 1'b0, 1'b1, 96);
    run_phase(11'd0, 11'd0, 14'd0, 1'b1, 1'b1, 32);
    run_phase(11'd1, 11'd129, 14'd16257, 1'b0, 1'b0, 32);
    run_phase(11'd129, 11'd1, 14'd16257, 1'b1, 1'b1, 32);
    run_phase(11'd1, 11'd1024, 14'd2048, 1'b0, 1'b1, 24);
    run_phase(11'd2047, 11'd1, 14'd1, 1'b0, 1'b1, 40);
    run_phase(11'd1, 11'd2047, 14'd16383, 1'b0, 1'b0, 40);
    run_phase(11'd1024, 11'd2, 14'd16383, 1'b1, 1'b1, 50);

    rstart = beats_sent;
    while (beats_sent - rstart < RANDOM_BEATS) begin
      dir = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: vals[dbtr_pkg::REG_BATCH] = 14'($urandom_range(0, 16383));
        1: vals[dbtr_pkg::REG_BATCH] = 14'd16383;
        2: vals[dbtr_pkg::REG_BATCH] = 14'd0;
        default: vals[dbtr_pkg::REG_BATCH] = 14'($urandom_range(1, 6));
      endcase
      run_phase(pick_extent(!dir), pick_extent(dir), vals[dbtr_pkg::REG_BATCH], dir,
                1'($urandom_range(0, 1)), 0);
    end

    din_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d input beats over %0d register settings plus the reset setting.",
             beats_sent, phases_run);
    $display("Checked %0d reordered words, %0d of them closing a pass; %0d mismatches.",
             results_checked, pass_ends, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls on ready, each accepted beat checked against the oldest
  // expected word.
  initial begin
    int      stall;
    word_t   got;
    result_t want;
    dout_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        dout_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dout_ch.valid) @(posedge clk);
      got = {dout_ch.out_lane_3, dout_ch.out_lane_2, dout_ch.out_lane_1, dout_ch.out_lane_0};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h last %b", $time, got,
                 dout_ch.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        for (int l = 0; l < dbtr_pkg::LANES; l++) begin
          if (got[l] !== want.word[l]) begin
            $display("%0t: out_lane_%0d expected %h got %h", $time, l, want.word[l], got[l]);
            errors++;
          end
        end
        if (dout_ch.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, dout_ch.last);
          errors++;
        end
        if (want.last) pass_ends++;
      end
    end
  end

endmodule

// ===== double_buffered_tile_reorder.f =====
+incdir+sv
sv/dbtr_pkg.sv
sv/dbtr_ifs.sv
sv/dbtr_ram.sv
sv/dbtr_seq.sv
sv/dbtr_outq.sv
sv/double_buffered_tile_reorder.sv
sv/dbtr_chk.sv
sim/double_buffered_tile_reorder_tb.sv
